@@ sv/optt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// optt_pkg: shared definitions of the timer slot table
// Function and status codes, field widths, defaults and the control state type.
// ----------------------------------------------------------------------------
package optt_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int MAX_REPORTS  = 16;
    localparam int CNT_W        = 5;
    localparam int DELAY_W      = 24;
    localparam int WAIT_W       = 16;
    localparam int ID_W         = 4;
    localparam int FUNC_W       = 2;
    localparam int STAT_W       = 2;

    localparam logic [WAIT_W-1:0] DEFAULT_WAIT = 16'd1000;

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ARM    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INACTIVE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

endpackage
`default_nettype wire

@@ sv/oneshot_periodic_timer_table_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oneshot_periodic_timer_table_top: one-shot and periodic millisecond timers
// Arms, cancels and ticks a table of timer slots held in one synchronous RAM.
//
//   Port group     Direction  Handshake               Content
//   command        in         start / busy            func, cancel_id, delay_ms, periodic
//   result         out        o_result_valid strobe   slot_id, status, fired, next_wait, last
//   configuration  in         i_cfg_we                max_wait
//
// Every command sweeps all slots through the slot RAM, one read per cycle with a
// write-back in the cycle after each read; busy stays high for the whole sweep, and
// a new command is accepted only while busy is low.
// Results of a tick stream out during the sweep; the final beat follows it.
// Reset is synchronous; the RAM contents are not cleared, since the active
// flags (flip-flops, cleared by reset) gate every read of an entry.
// The receiver cannot stall the result beats.
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_table_top #(
    parameter int SLOTS = optt_pkg::SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [optt_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [optt_pkg::ID_W-1:0]     i_cancel_id,
    input  wire logic [optt_pkg::DELAY_W-1:0]  i_delay_ms,
    input  wire logic                          i_periodic,
    input  wire logic                          i_cfg_we,
    input  wire logic [optt_pkg::WAIT_W-1:0]   i_cfg_wdata,
    output logic                               o_result_valid,
    output logic [optt_pkg::ID_W-1:0]          o_slot_id,
    output logic [optt_pkg::STAT_W-1:0]        o_status,
    output logic                               o_fired,
    output logic [optt_pkg::WAIT_W-1:0]        o_next_wait,
    output logic                               o_last
);
    import optt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW = ((IW > ID_W) ? IW : ID_W) + 1;
    localparam int MW = 2 * DELAY_W;

    // Slot RAM: {period, remaining} per slot.
    logic [MW-1:0]      mem [SLOTS];

    t_state             r_state;
    logic [SLOTS-1:0]   r_active;
    logic [SLOTS-1:0]   r_repeats;
    logic [WAIT_W-1:0]  r_max_wait;
    logic               r_rd_en;
    logic [IW-1:0]      r_rd_idx;
    logic               r_b_valid;
    logic [IW-1:0]      r_b_idx;
    logic [MW-1:0]      r_rd_data;
    logic               r_pend;
    logic [ID_W-1:0]    r_pend_id;
    logic [CNT_W-1:0]   r_cnt;
    logic [FUNC_W-1:0]  r_func;
    logic [ID_W-1:0]    r_res_slot;
    logic [STAT_W-1:0]  r_res_status;
    logic [WAIT_W-1:0]  r_min;
    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_slot;
    logic [STAT_W-1:0]  r_out_status;
    logic               r_out_fired;
    logic [WAIT_W-1:0]  r_out_wait;
    logic               r_out_last;

    logic               w_accept;
    logic [IW-1:0]      w_free_idx;
    logic               w_full;
    logic [TW-1:0]      w_tid_ext;
    logic [IW-1:0]      w_tid_idx;
    logic               w_tid_ok;
    logic               w_tick;
    logic               w_b_act;
    logic [DELAY_W-1:0] w_rem;
    logic [DELAY_W-1:0] w_per;
    logic [DELAY_W-1:0] w_dec;
    logic               w_expire;
    logic [DELAY_W-1:0] w_new_rem;
    logic               w_keep;
    logic [DELAY_W-1:0] w_cand;
    logic               w_min_upd;
    logic               w_take;
    logic               w_emit_b;
    logic               w_b_last;
    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic [MW-1:0]      w_wdata;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Lowest free slot for arming.
    always_comb begin
        w_free_idx = '0;
        w_full     = 1'b1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free_idx = IW'(i);
                w_full     = 1'b0;
            end
        end
    end

    assign w_tid_ext = TW'(i_cancel_id);
    assign w_tid_idx = w_tid_ext[IW-1:0];
    assign w_tid_ok  = (w_tid_ext < TW'(SLOTS)) && r_active[w_tid_idx];

    // Second stage of the sweep: the entry read in the previous cycle.
    assign w_tick    = (r_func == FUNC_TICK);
    assign w_b_act   = r_active[r_b_idx];
    assign w_rem     = r_rd_data[DELAY_W-1:0];
    assign w_per     = r_rd_data[MW-1:DELAY_W];
    assign w_dec     = (w_rem == '0) ? '0 : w_rem - DELAY_W'(1);
    assign w_expire  = r_b_valid && w_tick && w_b_act && (w_dec == '0);
    assign w_new_rem = w_expire ? (r_repeats[r_b_idx] ? w_per : '0) : w_dec;
    assign w_keep    = w_b_act && !(w_expire && !r_repeats[r_b_idx]);
    assign w_cand    = w_tick ? w_new_rem : w_rem;
    assign w_min_upd = r_b_valid && w_keep && (w_cand < DELAY_W'(r_min));
    assign w_take    = w_expire && (r_cnt < CNT_W'(MAX_REPORTS));
    assign w_emit_b  = w_take && r_pend;
    assign w_b_last  = r_b_valid && (r_b_idx == IW'(SLOTS - 1));

    // One write port: the arm at accept, otherwise the tick write-back.
    always_comb begin
        if (w_accept && (i_func == FUNC_ARM)) begin
            w_we    = !w_full;
            w_waddr = w_free_idx;
            w_wdata = {i_delay_ms, i_delay_ms};
        end else begin
            w_we    = r_b_valid && w_tick && w_b_act;
            w_waddr = r_b_idx;
            w_wdata = {w_per, w_new_rem};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (r_rd_en) begin
            r_rd_data <= mem[r_rd_idx];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_repeats   <= '0;
            r_max_wait  <= DEFAULT_WAIT;
            r_rd_en     <= 1'b0;
            r_rd_idx    <= '0;
            r_b_valid   <= 1'b0;
            r_b_idx     <= '0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_wait <= i_cfg_wdata;
            end
            r_out_valid <= w_emit_b || (r_state == S_FIN);
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state  <= S_RUN;
                        r_rd_en  <= 1'b1;
                        r_rd_idx <= '0;
                        r_pend   <= 1'b0;
                        r_cnt    <= '0;
                        if ((i_func == FUNC_ARM) && !w_full) begin
                            r_active[w_free_idx]  <= 1'b1;
                            r_repeats[w_free_idx] <= i_periodic;
                        end
                        if ((i_func == FUNC_CANCEL) && w_tid_ok) begin
                            r_active[w_tid_idx]  <= 1'b0;
                            r_repeats[w_tid_idx] <= 1'b0;
                        end
                    end
                end
                S_RUN: begin
                    r_b_valid <= r_rd_en;
                    r_b_idx   <= r_rd_idx;
                    if (r_rd_en) begin
                        if (r_rd_idx == IW'(SLOTS - 1)) begin
                            r_rd_en <= 1'b0;
                        end else begin
                            r_rd_idx <= r_rd_idx + IW'(1);
                        end
                    end
                    if (w_expire && !r_repeats[r_b_idx]) begin
                        r_active[r_b_idx] <= 1'b0;
                    end
                    if (w_take) begin
                        r_pend <= 1'b1;
                        r_cnt  <= r_cnt + CNT_W'(1);
                    end
                    if (w_b_last) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_b_valid <= 1'b0;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Command latches, running minimum and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_min  <= r_max_wait;
            case (i_func)
                FUNC_ARM: begin
                    r_res_slot   <= w_full ? '0 : ID_W'(w_free_idx);
                    r_res_status <= w_full ? STAT_FULL : STAT_OK;
                end
                FUNC_CANCEL: begin
                    r_res_slot   <= i_cancel_id;
                    r_res_status <= w_tid_ok ? STAT_OK : STAT_INACTIVE;
                end
                default: begin
                    r_res_slot   <= '0;
                    r_res_status <= STAT_OK;
                end
            endcase
        end
        if ((r_state == S_RUN) && w_min_upd) begin
            r_min <= WAIT_W'(w_cand);
        end
        if ((r_state == S_RUN) && w_take) begin
            r_pend_id <= ID_W'(r_b_idx);
        end
        if ((r_state == S_RUN) && w_emit_b) begin
            // An earlier expiry is released once a later one is known.
            r_out_slot   <= r_pend_id;
            r_out_status <= STAT_OK;
            r_out_fired  <= 1'b1;
            r_out_wait   <= '0;
            r_out_last   <= 1'b0;
        end else if (r_state == S_FIN) begin
            r_out_wait <= r_min;
            r_out_last <= 1'b1;
            if (r_func == FUNC_TICK) begin
                r_out_slot   <= r_pend ? r_pend_id : '0;
                r_out_status <= STAT_OK;
                r_out_fired  <= r_pend;
            end else begin
                r_out_slot   <= r_res_slot;
                r_out_status <= r_res_status;
                r_out_fired  <= 1'b0;
            end
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_slot_id      = r_out_slot;
    assign o_status       = r_out_status;
    assign o_fired        = r_out_fired;
    assign o_next_wait    = r_out_wait;
    assign o_last         = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_REPORTS))
        else $error("expiry report count exceeds its limit");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted command did not raise busy");

    a_mid_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last) |-> (o_fired && (o_status == STAT_OK)))
        else $error("non-final beat is not an expiry report");

    a_sweep_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_state == S_RUN))
        else $error("slot write-back outside the sweep");

    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (o_result_valid && o_last && !busy))
        else $error("final beat missing after the sweep");

endmodule
`default_nettype wire
